/* hdl/bfm_pkg.sv */
// ----------------------------------------------------------------------------
// bfm_pkg
// types and constants shared by the mip downsampler modules
// ----------------------------------------------------------------------------
`default_nettype none

package bfm_pkg;

  localparam int CHAN_W   = 8;
  localparam int SUM_W    = CHAN_W + 1;
  localparam int LANES    = 4;
  localparam int LINE_W   = LANES * SUM_W;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int ROW_W    = 12;
  localparam int CFG_W    = HEIGHT_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(256);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(256);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = HEIGHT_W'(4096);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] chan3;
    logic [CHAN_W-1:0] chan2;
    logic [CHAN_W-1:0] chan1;
    logic [CHAN_W-1:0] chan0;
    logic              frame_start;
  } pix_t;

  typedef struct packed {
    logic [CHAN_W-1:0] avg3;
    logic [CHAN_W-1:0] avg2;
    logic [CHAN_W-1:0] avg1;
    logic [CHAN_W-1:0] avg0;
    logic              frame_last;
  } mip_t;

  typedef struct packed {
    logic store_left;
    logic line_wr;
    logic emit;
    logic last;
  } pix_ctl_t;

endpackage

`default_nettype wire

/* hdl/bfm_if.sv */
// ----------------------------------------------------------------------------
// bfm_if
// valid/ready stream interfaces for input pixels and mip pixels
// ----------------------------------------------------------------------------
`default_nettype none

interface bfm_pix_if
  import bfm_pkg::*;
  ;
  logic valid;
  logic ready;
  pix_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bfm_mip_if
  import bfm_pkg::*;
  ;
  logic valid;
  logic ready;
  mip_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/bfm_ctrl.sv */
// ----------------------------------------------------------------------------
// bfm_ctrl
// size registers, column and row counters, per-pixel control decode
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_ctrl
  import bfm_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int COL_W     = $clog2(MAX_WIDTH),
  parameter int IDX_W     = $clog2(MAX_WIDTH / 2)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [CFG_W-1:0]     wr_data,
  input  wire logic                 accept,
  input  wire logic                 frame_start,
  output pix_ctl_t                  ctl,
  output logic [IDX_W-1:0]          idx
);

  localparam int CMP_W = (COL_W > WIDTH_W) ? COL_W : WIDTH_W;
  localparam logic [WIDTH_W-1:0] W_SAT = WIDTH_W'((MAX_WIDTH / 2) * 2);

  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  logic [COL_W-1:0]    column_count;
  logic [ROW_W-1:0]    row_count;
  logic [COL_W-1:0]    column_count_next;
  logic [ROW_W-1:0]    row_count_next;

  logic [WIDTH_W-1:0]  w_even;
  logic [WIDTH_W-1:0]  w_eff;
  logic [CMP_W-1:0]    w_last;
  logic [HEIGHT_W-1:0] h_eff;
  logic [HEIGHT_W-1:0] h_last;
  logic [HEIGHT_W-1:0] pair_end;
  logic [HEIGHT_W-1:0] pair_last;
  logic [COL_W-1:0]    col_cur;
  logic [ROW_W-1:0]    row_cur;
  logic [CMP_W-1:0]    col_ext;
  logic [HEIGHT_W-1:0] row_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_WIDTH:  width_reg  <= wr_data[WIDTH_W-1:0];
        REG_HEIGHT: height_reg <= wr_data[HEIGHT_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    w_even = {width_reg[WIDTH_W-1:1], 1'b0};
    w_eff  = w_even;
    if (32'(w_even) > MAX_WIDTH) w_eff = W_SAT;
    if (w_eff < WIDTH_W'(2)) w_eff = WIDTH_W'(2);
    w_last = CMP_W'(w_eff) - CMP_W'(1);

    h_eff = (height_reg > HEIGHT_MAX) ? HEIGHT_MAX : height_reg;
    h_last    = h_eff - HEIGHT_W'(1);
    pair_end  = {h_eff[HEIGHT_W-1:1], 1'b0};
    pair_last = pair_end - HEIGHT_W'(1);
  end

  always_comb begin
    col_cur = frame_start ? '0 : column_count;
    row_cur = frame_start ? '0 : row_count;
    col_ext = CMP_W'(col_cur);
    row_ext = HEIGHT_W'(row_cur);

    ctl.store_left = !col_cur[0];
    ctl.line_wr    = col_cur[0] && !row_cur[0];
    ctl.emit       = col_cur[0] && row_cur[0] && (row_ext < pair_end);
    ctl.last       = (row_ext == pair_last) && (col_ext == w_last);
    idx            = col_cur[IDX_W:1];

    if (col_ext >= w_last) begin
      column_count_next = '0;
      if (h_eff == '0 || row_ext >= h_last) begin
        row_count_next = '0;
      end else begin
        row_count_next = row_cur + ROW_W'(1);
      end
    end else begin
      column_count_next = col_cur + COL_W'(1);
      row_count_next    = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/bfm_line_buf.sv */
// ----------------------------------------------------------------------------
// bfm_line_buf
// line buffer of packed pair sums, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_line_buf
  import bfm_pkg::*;
#(
  parameter int DEPTH = 512,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [IDX_W-1:0]  wr_idx,
  input  wire logic [LINE_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [IDX_W-1:0]  rd_idx,
  output logic      [LINE_W-1:0] rd_data
);

  logic [LINE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

`default_nettype wire

/* hdl/bfm_lane.sv */
// ----------------------------------------------------------------------------
// bfm_lane
// one channel: horizontal pair sum, then vertical sum and divide by four
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_lane
  import bfm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [CHAN_W-1:0] left,
  input  wire logic [CHAN_W-1:0] cur,
  input  wire logic              load_pair,
  input  wire logic              load_avg,
  input  wire logic [SUM_W-1:0]  top,
  output logic      [SUM_W-1:0]  pair_sum,
  output logic      [CHAN_W-1:0] avg
);

  logic [SUM_W-1:0] bottom;
  logic [SUM_W:0]   block_sum;

  assign pair_sum  = SUM_W'(left) + SUM_W'(cur);
  assign block_sum = (SUM_W + 1)'(top) + (SUM_W + 1)'(bottom);

  always_ff @(posedge clk) begin
    if (load_pair) begin
      bottom <= pair_sum;
    end
    if (load_avg) begin
      avg <= block_sum[SUM_W:2];
    end
  end

endmodule

`default_nettype wire

/* hdl/box_filter_mip_downsampler.sv */
// ----------------------------------------------------------------------------
// box_filter_mip_downsampler
// 2x2 box filter that turns an rgba raster stream into the next mip level
// ----------------------------------------------------------------------------
// Accepts one pixel per clock while pixels.ready is high and gives one
// averaged pixel per 2x2 block: the block's last pixel loads the line buffer
// read and the lanes' bottom sums (s1), then the lanes' average registers (s2).
// Line buffer: at most one access per pixel pair (a write on even rows, a read
// on odd rows), MAX_WIDTH/2 entries of packed pair sums, no clearing after reset.
// Four channel lanes work side by side; input keeps flowing while one result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module box_filter_mip_downsampler
  import bfm_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [CFG_W-1:0]     wr_data,
  bfm_pix_if.sink                   pixels,
  bfm_mip_if.source                 mips
);

  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int IDX_W = $clog2(DEPTH);

  pix_ctl_t                     ctl;
  logic [IDX_W-1:0]             idx;
  logic                         accept;
  logic                         s1_valid;
  logic                         s1_last;
  logic                         s1_load;
  logic                         s2_load;
  logic                         out_valid;
  logic                         out_last;
  logic [LANES-1:0][CHAN_W-1:0] left_pixel;
  logic [LANES-1:0][CHAN_W-1:0] cur_pixel;
  logic [LANES-1:0][SUM_W-1:0]  pair_sums;
  logic [LANES-1:0][CHAN_W-1:0] avgs;
  logic [LINE_W-1:0]            top_sums;

  assign s2_load      = s1_valid && (!out_valid || mips.ready);
  assign pixels.ready = !s1_valid || s2_load;
  assign accept       = pixels.valid && pixels.ready;
  assign s1_load      = accept && ctl.emit;

  assign cur_pixel = {pixels.data.chan3, pixels.data.chan2,
                      pixels.data.chan1, pixels.data.chan0};

  bfm_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .accept      (accept),
    .frame_start (pixels.data.frame_start),
    .ctl         (ctl),
    .idx         (idx)
  );

  bfm_line_buf #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (accept && ctl.line_wr),
    .wr_idx  (idx),
    .wr_data (pair_sums),
    .rd_en   (s1_load),
    .rd_idx  (idx),
    .rd_data (top_sums)
  );

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    bfm_lane u_lane (
      .clk       (clk),
      .left      (left_pixel[k]),
      .cur       (cur_pixel[k]),
      .load_pair (s1_load),
      .load_avg  (s2_load),
      .top       (top_sums[k*SUM_W +: SUM_W]),
      .pair_sum  (pair_sums[k]),
      .avg       (avgs[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel <= '0;
    end else if (accept && ctl.store_left) begin
      left_pixel <= cur_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= 1'b1;
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
      if (s2_load) begin
        out_valid <= 1'b1;
      end else if (mips.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_last <= ctl.last;
    end
    if (s2_load) begin
      out_last <= s1_last;
    end
  end

  assign mips.valid           = out_valid;
  assign mips.data.avg0       = avgs[0];
  assign mips.data.avg1       = avgs[1];
  assign mips.data.avg2       = avgs[2];
  assign mips.data.avg3       = avgs[3];
  assign mips.data.frame_last = out_last;

endmodule

`default_nettype wire
